// ===== rtl/core/b64d_pkg.sv =====
// Shared types, result kinds and the alphabet decode for the base64 stream decoder.
// No dependencies.
package b64d_pkg;

	localparam int unsigned MaxResults = 4;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_END_OK   = 3'd1,
		KIND_INVALID  = 3'd2,
		KIND_BAD_LEN  = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	// one result: data byte plus its kind
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	// all results caused by one item, cnt is 0..4 (0 when the item gives none)
	typedef struct packed {
		logic [2:0]                cnt;
		res_t [MaxResults-1:0]     res;
	} bundle_t;

	// decoded character
	typedef struct packed {
		logic       ok;   // in the alphabet
		logic       pad;  // '='
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s = '{ok: 1'b0, pad: 1'b0, val: 6'd0};
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.ok  = 1'b1;
			s.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.ok  = 1'b1;
			s.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.ok  = 1'b1;
			s.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s.ok  = 1'b1;
			s.val = 6'd62;
		end else if (c == 8'h2F) begin
			s.ok  = 1'b1;
			s.val = 6'd63;
		end else if (c == 8'h3D) begin
			s.pad = 1'b1;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/b64d_out_buf.sv =====
// Result buffer of the base64 decoder: holds the results of one item and
// hands them out one per cycle while the sink is ready. Depends on b64d_pkg.
module b64d_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  b64d_pkg::bundle_t bundle,
	output logic              free,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // out_byte
	output logic [2:0]        m_axis_tuser,  // kind
	output logic              m_axis_tlast   // run_end
);
	import b64d_pkg::*;

	logic       valid_q;
	logic [1:0] idx_q;
	bundle_t    bundle_q;
	logic       last;

	assign last          = ({1'b0, idx_q} == bundle_q.cnt - 3'd1);
	assign free          = !valid_q || (m_axis_tready && last);
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = bundle_q.res[idx_q].data;
	assign m_axis_tuser  = bundle_q.res[idx_q].kind;
	assign m_axis_tlast  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && m_axis_tready) begin
			if (last) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, idx_q} < bundle_q.cnt))
		else $error("result index beyond bundle count");
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (bundle_q.cnt != 3'd0))
		else $error("empty bundle held");
	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (idx_q == 2'd0 && valid_q))
		else $error("load did not restart at first result");

endmodule

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// Top level of the streaming base64 decoder (RFC 4648 alphabet).
// Depends on b64d_pkg and b64d_out_buf.
//
// One character per item enters on s_axis, tlast marks the last character of a
// string. Characters are registered, then decoded against the group state; each
// fourth character yields up to three data bytes (kind 0), and
// the final character adds an end-ok status (kind 1). Errors give a single
// status item (2 invalid char, 3 bad length, 4 overflow of output_capacity),
// after which the string's remaining characters give nothing; the final
// character always clears the string state. m_axis tlast marks the last result
// of each character. Rate: one character per cycle; a group's two to four
// results drain from the result buffer at one per cycle, overlapping the next
// group's first characters, so a stream sustains one character per cycle
// while the sink takes results every cycle. output_capacity is written through
// cfg_wr_en / cfg_wr_data; the user must do so only while the block is idle, the block does not enforce it.
module base64_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,   // output_capacity
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_code
	input  logic        s_axis_tlast,  // final_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_byte
	output logic [2:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast   // run_end
);
	import b64d_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        fin_s1;

	// string state
	logic [23:0] cap_q;
	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic [1:0]  pad_q;
	logic        err_q;
	logic [23:0] emitted_q;

	logic [1:0]  pos_d;
	logic [17:0] acc_d;
	logic [1:0]  pad_d;
	logic        err_d;
	logic [23:0] emitted_d;

	sextet_t     sx;
	logic [5:0]  val;
	logic [23:0] piece;
	logic [1:0]  nbytes;
	logic [24:0] sum;
	logic        has_err;
	kind_t       err_kind;
	logic [2:0]  n;
	bundle_t     bundle;
	logic        buf_free;
	logic        fire;
	logic        load;

	assign fire          = valid_s1 && (n == 3'd0 || buf_free);
	assign load          = fire && (n != 3'd0);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			fin_s1  <= s_axis_tlast;
		end
	end

	// decode of the registered character against the group state
	always_comb begin
		sx        = sextet_of(char_s1);
		val       = sx.pad ? 6'd0 : sx.val;
		piece     = {acc_q, val};
		pos_d     = pos_q;
		acc_d     = acc_q;
		pad_d     = pad_q;
		err_d     = err_q;
		emitted_d = emitted_q;
		has_err   = 1'b0;
		err_kind  = KIND_INVALID;
		n         = 3'd0;
		nbytes    = 2'd0;
		sum       = 25'd0;
		bundle    = '0;

		if (!err_q) begin
			if (!sx.ok && !sx.pad) begin
				has_err = 1'b1;
			end else if (sx.pad) begin
				// padding only in the third or fourth place
				if (pos_q < 2'd2) begin
					has_err = 1'b1;
				end else begin
					pad_d = pad_q + 2'd1;
				end
			end else if (pad_q != 2'd0) begin
				// data after padding in the same group
				has_err = 1'b1;
			end

			if (!has_err) begin
				if (pos_q == 2'd3) begin
					nbytes = 2'd3 - pad_d;
					sum    = {1'b0, emitted_q} + {23'd0, nbytes};
					if (pad_d != 2'd0 && !fin_s1) begin
						// padded group not at end of string
						has_err = 1'b1;
					end else if (sum > {1'b0, cap_q}) begin
						has_err  = 1'b1;
						err_kind = KIND_OVERFLOW;
					end else begin
						bundle.res[0] = '{data: piece[23:16], kind: KIND_DATA};
						bundle.res[1] = '{data: piece[15:8],  kind: KIND_DATA};
						bundle.res[2] = '{data: piece[7:0],   kind: KIND_DATA};
						n             = {1'b0, nbytes};
						if (fin_s1) begin
							bundle.res[n[1:0]] = '{data: 8'd0, kind: KIND_END_OK};
							n = n + 3'd1;
						end
						emitted_d = sum[23:0];
						pos_d     = 2'd0;
						acc_d     = 18'd0;
						pad_d     = 2'd0;
					end
				end else begin
					acc_d = {acc_q[11:0], val};
					pos_d = pos_q + 2'd1;
					if (fin_s1) begin
						has_err  = 1'b1;
						err_kind = KIND_BAD_LEN;
					end
				end
			end

			if (has_err) begin
				bundle.res[0] = '{data: 8'd0, kind: err_kind};
				n             = 3'd1;
				err_d         = 1'b1;
			end
		end

		bundle.cnt = n;

		// end of string returns all string state to reset
		if (fin_s1) begin
			pos_d     = 2'd0;
			acc_d     = 18'd0;
			pad_d     = 2'd0;
			err_d     = 1'b0;
			emitted_d = 24'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= 24'hFFFFFF;
			pos_q     <= 2'd0;
			acc_q     <= 18'd0;
			pad_q     <= 2'd0;
			err_q     <= 1'b0;
			emitted_q <= 24'd0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (fire) begin
				pos_q     <= pos_d;
				acc_q     <= acc_d;
				pad_q     <= pad_d;
				err_q     <= err_d;
				emitted_q <= emitted_d;
			end
		end
	end

	b64d_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.bundle        (bundle),
		.free          (buf_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_latched_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && err_q) |-> !load)
		else $error("results after latched error");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> buf_free)
		else $error("result buffer overwritten");
	a_acc_clear_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == 2'd0) |-> (acc_q == 18'd0 && pad_q == 2'd0))
		else $error("group state not cleared at group start");

endmodule
